@@ sv/sgd_pkg.sv @@
// sgd_pkg: shared constants, register codes and item structs of the sobel
// gradient block. No dependencies.
package sgd_pkg;

  localparam int unsigned MaxWidthDefault = 512;

  localparam int unsigned PixW   = 8;
  localparam int unsigned RowW   = 12;
  localparam int unsigned ColW   = 9;
  localparam int unsigned FwW    = 10;
  localparam int unsigned GradW  = 10;
  localparam int unsigned SqW    = 20;
  localparam int unsigned SumW   = 21;
  localparam int unsigned CmpW   = 22;
  localparam int unsigned RootW  = 16;
  localparam int unsigned MagW   = 8;
  localparam int unsigned DirW   = 2;
  localparam int unsigned NumRootSteps = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [FwW-1:0]  FrameWidthReset  = 10'd320;
  localparam logic [RowW-1:0] FrameHeightReset = 12'd240;
  localparam logic [MagW-1:0] MagSat           = 8'd255;

  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } sgd_reg_e;

  localparam logic [DirW-1:0] Dir0   = 2'd0;
  localparam logic [DirW-1:0] Dir45  = 2'd1;
  localparam logic [DirW-1:0] Dir90  = 2'd2;
  localparam logic [DirW-1:0] Dir135 = 2'd3;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            frame_end;
  } sgd_meta_t;

  typedef struct packed {
    logic             valid;
    logic [GradW-1:0] a;
    logic [GradW-1:0] b;
    logic             same;
    sgd_meta_t        meta;
  } sgd_grad_t;

  typedef struct packed {
    logic             sat;
    logic [DirW-1:0]  dir;
    logic [RootW-1:0] rem;
    logic [RootW-1:0] root;
    sgd_meta_t        meta;
  } sgd_cell_t;

endpackage

@@ sv/sgd_front.sv @@
// sgd_front: row/column counters, line memory, 3x3 window and sobel sums.
// Depends on sgd_pkg.
module sgd_front #(
  parameter int unsigned MAX_WIDTH = sgd_pkg::MaxWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [sgd_pkg::PixW-1:0]     pixel_i,
  input  logic                         frame_start_i,
  input  logic                         s1_ready_i,
  input  logic [sgd_pkg::FwW-1:0]      frame_width_i,
  input  logic [sgd_pkg::RowW-1:0]     frame_height_i,
  output logic                         in_stall_o,
  output sgd_pkg::sgd_grad_t           grad_o
);
  import sgd_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned MWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW  = (MWW > FwW) ? MWW : FwW;
  localparam logic [XW-1:0] WMax = XW'(MAX_WIDTH);
  localparam logic [XW-1:0] WMin = XW'(3);

  typedef enum logic {FE_IDLE, FE_WORK} fe_state_e;

  fe_state_e         state_q;
  logic [RowW-1:0]   row_count_q, row_count_d;
  logic [CW-1:0]     col_count_q, col_count_d;
  logic [RowW-1:0]   row_q, row_cur;
  logic [CW-1:0]     col_q, col_cur;
  logic [PixW-1:0]   pix_q;
  logic              int_q, int_d;
  logic              fe_q, fe_d;
  logic [PixW-1:0]   win_q [6];
  logic [2*PixW-1:0] rd_q;
  logic [2*PixW-1:0] mem [MAX_WIDTH];

  logic              accept;
  logic [XW-1:0]     w_ext, w_eff, col_inc;
  logic [RowW-1:0]   h_eff;
  logic [RowW:0]     row_inc;
  logic [PixW-1:0]   top, mid;
  logic [GradW-1:0]  pos_h, neg_h, pos_v, neg_v;

  assign in_stall_o = (state_q == FE_WORK) || !s1_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    row_cur = frame_start_i ? '0 : row_count_q;
    col_cur = frame_start_i ? '0 : col_count_q;
    w_ext   = XW'(frame_width_i);
    if (w_ext < WMin) begin
      w_eff = WMin;
    end else if (w_ext > WMax) begin
      w_eff = WMax;
    end else begin
      w_eff = w_ext;
    end
    h_eff   = (frame_height_i < RowW'(3)) ? RowW'(3) : frame_height_i;
    col_inc = XW'(col_cur) + XW'(1);
    row_inc = {1'b0, row_cur} + (RowW+1)'(1);
    if (col_inc >= w_eff) begin
      col_count_d = '0;
      row_count_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RowW-1:0];
    end else begin
      col_count_d = col_inc[CW-1:0];
      row_count_d = row_cur;
    end
    int_d = (row_cur >= RowW'(2)) && (col_cur >= CW'(2));
    fe_d  = (row_cur == h_eff - RowW'(1)) && (XW'(col_cur) == w_eff - XW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FE_IDLE;
      row_count_q <= '0;
      col_count_q <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      case (state_q)
        FE_IDLE: begin
          if (accept) begin
            state_q     <= FE_WORK;
            row_count_q <= row_count_d;
            col_count_q <= col_count_d;
          end
        end
        FE_WORK: begin
          state_q  <= FE_IDLE;
          win_q[0] <= win_q[3];
          win_q[1] <= win_q[4];
          win_q[2] <= win_q[5];
          win_q[3] <= top;
          win_q[4] <= mid;
          win_q[5] <= pix_q;
        end
        default: state_q <= FE_IDLE;
      endcase
    end
  end

  // item fields held for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_i;
      row_q <= row_cur;
      col_q <= col_cur;
      int_q <= int_d;
      fe_q  <= fe_d;
    end
  end

  // line memory: upper byte two rows up, lower byte one row up
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[col_cur];
    end
    if (state_q == FE_WORK) begin
      mem[col_q] <= {rd_q[PixW-1:0], pix_q};
    end
  end

  assign top = rd_q[2*PixW-1:PixW];
  assign mid = rd_q[PixW-1:0];

  always_comb begin
    pos_h = GradW'(win_q[0]) + {1'b0, win_q[3], 1'b0} + GradW'(top);
    neg_h = GradW'(win_q[2]) + {1'b0, win_q[5], 1'b0} + GradW'(pix_q);
    pos_v = GradW'(win_q[0]) + {1'b0, win_q[1], 1'b0} + GradW'(win_q[2]);
    neg_v = GradW'(top) + {1'b0, mid, 1'b0} + GradW'(pix_q);

    grad_o.valid = (state_q == FE_WORK) && int_q;
    grad_o.a     = (pos_v >= neg_v) ? pos_v - neg_v : neg_v - pos_v;
    grad_o.b     = (pos_h >= neg_h) ? pos_h - neg_h : neg_h - pos_h;
    grad_o.same  = (pos_v > neg_v) == (pos_h > neg_h);
    grad_o.meta.row       = row_q - RowW'(1);
    grad_o.meta.col       = ColW'(col_q - CW'(1));
    grad_o.meta.frame_end = fe_q;
  end

endmodule

@@ sv/sgd_sqrt_cell.sv @@
// sgd_sqrt_cell: one digit step of the integer square root, registered.
// Depends on sgd_pkg.
module sgd_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               valid_i,
  input  sgd_pkg::sgd_cell_t cell_i,
  output logic               valid_o,
  output sgd_pkg::sgd_cell_t cell_o
);
  import sgd_pkg::*;

  localparam logic [RootW:0] Bit = (RootW+1)'(1) << (2 * (NumRootSteps - 1 - STEP));

  logic               valid_q;
  sgd_cell_t          cell_q, cell_d;
  logic [RootW:0]     trial;

  always_comb begin
    cell_d = cell_i;
    trial  = {1'b0, cell_i.root} + Bit;
    if ({1'b0, cell_i.rem} >= trial) begin
      cell_d.rem  = cell_i.rem - trial[RootW-1:0];
      cell_d.root = (cell_i.root >> 1) + Bit[RootW-1:0];
    end else begin
      cell_d.root = cell_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

@@ sv/sobel_gradient_direction_stream.sv @@
// sobel_gradient_direction_stream: top level with register port, square and
// sector stages, square root cell chain and output register.
// Depends on sgd_pkg, sgd_front and sgd_sqrt_cell.
//
// Pixels arrive in raster order: the line memory (MAX_WIDTH words of two
// pixels, one port) is read at the edge that takes the pixel and written
// back in the following cycle, so no new pixel is accepted while that
// write-back is pending. Each interior window centre yields one result,
// carried through registered stages in order: gradient, squares, sum and
// sector test, eight square root cells, then the output register. A stall on
// the result side backs up through the chain and then holds off input. The
// line memory has no reset; a frame fills it before any row of results uses
// it. Geometry writes are meant to be made while the block is idle.
module sobel_gradient_direction_stream #(
  parameter int unsigned MAX_WIDTH = sgd_pkg::MaxWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgd_pkg::CfgAddrW-1:0]   paddr,
  input  logic [sgd_pkg::CfgDataW-1:0]   pwdata,
  output logic [sgd_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sgd_pkg::PixW-1:0]       pixel_i,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sgd_pkg::MagW-1:0]       magnitude_o,
  output logic [sgd_pkg::DirW-1:0]       direction_o,
  output logic [sgd_pkg::RowW-1:0]       centre_row_o,
  output logic [sgd_pkg::ColW-1:0]       centre_col_o,
  output logic                           frame_end_o
);
  import sgd_pkg::*;

  logic [FwW-1:0]  width_q;
  logic [RowW-1:0] height_q;
  sgd_reg_e        cfg_idx;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = sgd_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FrameWidthReset;
      height_q <= FrameHeightReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegFrameWidth:  width_q  <= pwdata[FwW-1:0];
        RegFrameHeight: height_q <= pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegFrameWidth:  prdata = CfgDataW'(width_q);
      RegFrameHeight: prdata = CfgDataW'(height_q);
      default:        prdata = '0;
    endcase
  end

  // ready chain from the output register back to the gradient stage
  logic                  s1_rdy, s2_rdy, s3_rdy, out_rdy;
  logic [NumRootSteps-1:0] cell_rdy;
  logic [NumRootSteps-1:0] cell_v;
  sgd_cell_t             cell_q [NumRootSteps];

  sgd_grad_t grad;

  sgd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .pixel_i        (pixel_i),
    .frame_start_i  (frame_start_i),
    .s1_ready_i     (s1_rdy),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .in_stall_o     (in_stall_o),
    .grad_o         (grad)
  );

  // gradient stage
  logic      s1_v_q;
  sgd_grad_t s1_q;

  // squares stage
  logic            s2_v_q;
  logic [SqW-1:0]  a2_q, b2_q, ab_q;
  logic            gt_q, same2_q;
  sgd_meta_t       meta2_q;

  // sum and sector stage
  logic      s3_v_q;
  sgd_cell_t s3_q, s3_d;
  logic [CmpW-1:0] a2e, b2e, ab2e;
  logic [SumW-1:0] sum;
  logic            sec0, sec2;

  // output register
  logic      out_v_q;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign cell_rdy[NumRootSteps-1] = !cell_v[NumRootSteps-1] || out_rdy;
  for (genvar i = 0; i < NumRootSteps - 1; i++) begin : g_rdy
    assign cell_rdy[i] = !cell_v[i] || cell_rdy[i+1];
  end
  assign s3_rdy = !s3_v_q || cell_rdy[0];
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= grad.valid;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (out_rdy) begin
        out_v_q <= cell_v[NumRootSteps-1];
      end
    end
  end

  always_comb begin
    a2e  = CmpW'(a2_q);
    b2e  = CmpW'(b2_q);
    ab2e = {CmpW'(ab_q)} << 1;
    sum  = SumW'(a2_q) + SumW'(b2_q);
    sec0 = (a2e + ab2e) <= b2e;
    sec2 = gt_q && (a2e >= b2e + ab2e);
    s3_d.sat  = (sum[SumW-1:RootW] != '0);
    s3_d.rem  = sum[RootW-1:0];
    s3_d.root = '0;
    s3_d.meta = meta2_q;
    if (sec0) begin
      s3_d.dir = Dir0;
    end else if (sec2) begin
      s3_d.dir = Dir90;
    end else if (same2_q) begin
      s3_d.dir = Dir45;
    end else begin
      s3_d.dir = Dir135;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_q <= grad;
    end
    if (s2_rdy) begin
      a2_q    <= SqW'(s1_q.a) * SqW'(s1_q.a);
      b2_q    <= SqW'(s1_q.b) * SqW'(s1_q.b);
      ab_q    <= SqW'(s1_q.a) * SqW'(s1_q.b);
      gt_q    <= s1_q.a > s1_q.b;
      same2_q <= s1_q.same;
      meta2_q <= s1_q.meta;
    end
    if (s3_rdy) begin
      s3_q <= s3_d;
    end
  end

  for (genvar i = 0; i < NumRootSteps; i++) begin : g_cell
    if (i == 0) begin : g_first
      sgd_sqrt_cell #(.STEP(i)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .load_i  (cell_rdy[i]),
        .valid_i (s3_v_q),
        .cell_i  (s3_q),
        .valid_o (cell_v[i]),
        .cell_o  (cell_q[i])
      );
    end else begin : g_next
      sgd_sqrt_cell #(.STEP(i)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .load_i  (cell_rdy[i]),
        .valid_i (cell_v[i-1]),
        .cell_i  (cell_q[i-1]),
        .valid_o (cell_v[i]),
        .cell_o  (cell_q[i])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      magnitude_o  <= cell_q[NumRootSteps-1].sat ? MagSat
                                                 : cell_q[NumRootSteps-1].root[MagW-1:0];
      direction_o  <= cell_q[NumRootSteps-1].dir;
      centre_row_o <= cell_q[NumRootSteps-1].meta.row;
      centre_col_o <= cell_q[NumRootSteps-1].meta.col;
      frame_end_o  <= cell_q[NumRootSteps-1].meta.frame_end;
    end
  end

  assign out_valid_o = out_v_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grad.valid |-> !s1_v_q)
    else $error("gradient item pushed into a full stage");

  a_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item taken while line memory update pending");

  a_flat_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && magnitude_o == '0) |-> direction_o == Dir0)
    else $error("zero gradient with nonzero direction");

  a_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> centre_row_o != '0)
    else $error("frame end on border row");

endmodule
